FILE: rtl/mps_pkg.sv
// shared types, codes and the dead-end replacement rules of the maze path simplifier
package mps_pkg;

  localparam int IndexW = 8;

  typedef enum logic [1:0] {
    MV_L = 2'd0,
    MV_R = 2'd1,
    MV_U = 2'd2,
    MV_F = 2'd3
  } mps_move_e;

  typedef enum logic [1:0] {
    CMD_APPEND   = 2'd0,
    CMD_SIMPLIFY = 2'd1,
    CMD_READ     = 2'd2,
    CMD_CLEAR    = 2'd3
  } mps_cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_PUSH,
    ST_REFILL,
    ST_COPY,
    ST_DONE
  } mps_state_e;

  typedef struct packed {
    logic start;
    logic ack;
  } mps_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mps_stat_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mps_pmem_t;

  typedef struct packed {
    logic      hit;
    mps_move_e mv;
  } mps_rule_t;

  // replacement for the triple first, U-turn, third
  function automatic mps_rule_t mps_rule(input logic side, input mps_move_e first,
                                         input mps_move_e third);
    mps_rule_t r;
    r = '{hit: 1'b0, mv: MV_L};
    case ({side, first, third})
      {1'b0, MV_R, MV_R}: r = '{hit: 1'b1, mv: MV_F};
      {1'b0, MV_F, MV_R}: r = '{hit: 1'b1, mv: MV_L};
      {1'b0, MV_R, MV_F}: r = '{hit: 1'b1, mv: MV_L};
      {1'b0, MV_L, MV_R}: r = '{hit: 1'b1, mv: MV_U};
      {1'b0, MV_R, MV_L}: r = '{hit: 1'b1, mv: MV_U};
      {1'b1, MV_L, MV_L}: r = '{hit: 1'b1, mv: MV_F};
      {1'b1, MV_F, MV_L}: r = '{hit: 1'b1, mv: MV_R};
      {1'b1, MV_L, MV_F}: r = '{hit: 1'b1, mv: MV_R};
      {1'b1, MV_R, MV_L}: r = '{hit: 1'b1, mv: MV_U};
      {1'b1, MV_L, MV_R}: r = '{hit: 1'b1, mv: MV_U};
      default:            r = '{hit: 1'b0, mv: MV_L};
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/mps_if.sv
// command and result channel interfaces of the maze path simplifier
interface mps_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [1:0] move;
  logic [7:0] index;

  modport source (output valid, output cmd, output move, output index, input ready);
  modport sink (input valid, input cmd, input move, input index, output ready);
endinterface

interface mps_out_if #(
  parameter int CountW = 9
);
  logic              valid;
  logic              ready;
  logic [1:0]        move_out;
  logic [CountW-1:0] path_length;
  logic              full_flag;
  logic              index_bad;

  modport source (output valid, output move_out, output path_length, output full_flag,
                  output index_bad, input ready);
  modport sink (input valid, input move_out, input path_length, input full_flag,
                input index_bad, output ready);
endinterface

FILE: rtl/mps_reducer.sv
// pass sequencer that shortens the path through the work stack memory
module mps_reducer #(
  parameter int PathDepth
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  mps_pkg::mps_ctrl_t                   ctrl_i,
  input  logic                                 side_i,
  input  logic [$clog2(PathDepth+1)-1:0]       count_i,
  output mps_pkg::mps_stat_t                   stat_o,
  output logic [$clog2(PathDepth+1)-1:0]       count_o,
  output mps_pkg::mps_pmem_t                   pm_o,
  output logic [$clog2(PathDepth)-1:0]         p_raddr_o,
  output logic [$clog2(PathDepth)-1:0]         p_waddr_o,
  output logic [1:0]                           p_wdata_o,
  input  logic [1:0]                           p_rdata_i
);
  import mps_pkg::*;

  localparam int AW   = $clog2(PathDepth);
  localparam int CntW = $clog2(PathDepth + 1);

  mps_state_e state_q, state_d;

  logic [CntW-1:0] i_q, i_d;
  logic [CntW-1:0] depth_q, depth_d;
  logic [CntW-1:0] len_q, len_d;
  logic [CntW-1:0] c_q, c_d;
  mps_move_e       top_q, top_d;
  mps_move_e       sec_q, sec_d;
  logic            changed_q, changed_d;

  logic [1:0]    w_mem [PathDepth];
  logic [1:0]    w_rdata_q;
  logic          w_we, w_re;
  logic [AW-1:0] w_waddr, w_raddr;
  logic [1:0]    w_wdata;

  mps_move_e       x;
  mps_rule_t       rule;
  logic            match;
  logic            deep;
  logic            last;
  logic [CntW-1:0] i_m1, i_m2, d_m2, d_m3, c_m1, cp_src;

  assign x      = mps_move_e'(p_rdata_i);
  assign rule   = mps_rule(side_i, sec_q, x);
  assign match  = (depth_q >= CntW'(2)) && (top_q == MV_U) && rule.hit;
  assign deep   = depth_q >= CntW'(3);
  assign last   = i_q == CntW'(1);
  assign i_m1   = i_q - CntW'(1);
  assign i_m2   = i_q - CntW'(2);
  assign d_m2   = depth_q - CntW'(2);
  assign d_m3   = depth_q - CntW'(3);
  assign c_m1   = c_q - CntW'(1);
  assign cp_src = depth_q - CntW'(1) - c_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (ctrl_i.start) begin
          state_d = (count_i < CntW'(3)) ? ST_DONE : ST_FETCH;
        end
      end
      ST_FETCH: state_d = ST_PUSH;
      ST_PUSH: begin
        if (last) begin
          state_d = (changed_q || match) ? ST_COPY : ST_DONE;
        end else if (match && deep) begin
          state_d = ST_REFILL;
        end
      end
      ST_REFILL: state_d = ST_PUSH;
      ST_COPY: begin
        if (c_q == depth_q) begin
          state_d = deep ? ST_FETCH : ST_DONE;
        end
      end
      ST_DONE: begin
        if (ctrl_i.ack) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    i_d       = i_q;
    depth_d   = depth_q;
    len_d     = len_q;
    c_d       = c_q;
    top_d     = top_q;
    sec_d     = sec_q;
    changed_d = changed_q;
    pm_o      = '0;
    p_raddr_o = '0;
    p_waddr_o = '0;
    p_wdata_o = w_rdata_q;
    w_we      = 1'b0;
    w_re      = 1'b0;
    w_waddr   = '0;
    w_raddr   = '0;
    w_wdata   = x;
    stat_o.busy = state_q != ST_IDLE;
    stat_o.done = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (ctrl_i.start) begin
          i_d       = count_i;
          len_d     = count_i;
          depth_d   = '0;
          c_d       = '0;
          changed_d = 1'b0;
        end
      end
      ST_FETCH: begin
        pm_o.rd_en = 1'b1;
        p_raddr_o  = i_m1[AW-1:0];
      end
      ST_PUSH: begin
        i_d  = i_m1;
        w_we = 1'b1;
        if (match) begin
          w_waddr   = d_m2[AW-1:0];
          w_wdata   = rule.mv;
          top_d     = rule.mv;
          depth_d   = depth_q - CntW'(1);
          changed_d = 1'b1;
          if (deep && !last) begin
            w_re    = 1'b1;
            w_raddr = d_m3[AW-1:0];
          end
        end else begin
          w_waddr = depth_q[AW-1:0];
          sec_d   = top_q;
          top_d   = x;
          depth_d = depth_q + CntW'(1);
        end
        if (!last && !(match && deep)) begin
          pm_o.rd_en = 1'b1;
          p_raddr_o  = i_m2[AW-1:0];
        end
      end
      ST_REFILL: begin
        sec_d      = mps_move_e'(w_rdata_q);
        pm_o.rd_en = 1'b1;
        p_raddr_o  = i_m1[AW-1:0];
      end
      ST_COPY: begin
        if (c_q != '0) begin
          pm_o.wr_en = 1'b1;
          p_waddr_o  = c_m1[AW-1:0];
        end
        if (c_q != depth_q) begin
          w_re    = 1'b1;
          w_raddr = cp_src[AW-1:0];
          c_d     = c_q + CntW'(1);
        end else begin
          len_d     = depth_q;
          i_d       = depth_q;
          depth_d   = '0;
          c_d       = '0;
          changed_d = 1'b0;
        end
      end
      ST_DONE: stat_o.done = 1'b1;
      default: ;
    endcase
  end

  assign count_o = len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      i_q       <= '0;
      depth_q   <= '0;
      len_q     <= '0;
      c_q       <= '0;
      changed_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      i_q       <= i_d;
      depth_q   <= depth_d;
      len_q     <= len_d;
      c_q       <= c_d;
      changed_q <= changed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    sec_q <= sec_d;
  end

  // work stack memory
  always_ff @(posedge clk_i) begin
    if (w_we) begin
      w_mem[w_waddr] <= w_wdata;
    end
    if (w_re) begin
      w_rdata_q <= w_mem[w_raddr];
    end
  end

endmodule

FILE: rtl/maze_path_simplifier.sv
// top level of the maze path simplifier: path store, command decode and result stage
// Records robot moves in a path store and answers one result per command transaction.
// Append, read and clear are taken one per cycle while the receiver does not hold off
// results and no simplify runs; a result passes through a command stage and an output
// register. Simplify holds off new commands while the pass sequencer runs: each pass
// pushes every stored move onto the work stack, a pass that shortened the path then
// copies the work stack back, and passes repeat until one leaves the path as it is or
// the path is shorter than three moves; each memory has a single read and write port.
// Paths shorter than three moves go straight to done without a pass.
module maze_path_simplifier #(
  parameter int PATH_DEPTH = 256
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i,
  mps_in_if.sink   cmd_i,
  mps_out_if.source res_o
);
  import mps_pkg::*;

  localparam int AW   = $clog2(PATH_DEPTH);
  localparam int CntW = $clog2(PATH_DEPTH + 1);
  localparam int CmpW = (CntW > IndexW) ? CntW : IndexW;

  logic            side_q;
  logic [CntW-1:0] count_q, count_d;

  logic [1:0]    p_mem [PATH_DEPTH];
  logic [1:0]    p_rdata_q;
  logic          p_we, p_re;
  logic [AW-1:0] p_waddr, p_raddr;
  logic [1:0]    p_wdata;

  logic            s1_valid_q, s1_valid_d;
  logic [CntW-1:0] s1_len_q, s1_len_d;
  logic            s1_full_q, s1_full_d;
  logic            s1_bad_q, s1_bad_d;
  logic            s1_rd_q, s1_rd_d;

  logic            o_valid_q;
  logic [1:0]      o_move_q;
  logic [CntW-1:0] o_len_q;
  logic            o_full_q;
  logic            o_bad_q;

  logic      accept, out_free, s1_free, s1_load;
  logic      is_full, in_range, do_append, do_read;
  logic [CmpW-1:0] idx_c, cnt_c;

  mps_ctrl_t       red_ctrl;
  mps_stat_t       red_stat;
  mps_pmem_t       red_pm;
  logic [CntW-1:0] red_count;
  logic [AW-1:0]   red_raddr, red_waddr;
  logic [1:0]      red_wdata;

  assign out_free = !o_valid_q || res_o.ready;
  assign s1_free  = !s1_valid_q || out_free;
  assign cmd_i.ready = !red_stat.busy && s1_free;
  assign accept   = cmd_i.valid && cmd_i.ready;

  assign idx_c    = CmpW'(cmd_i.index);
  assign cnt_c    = CmpW'(count_q);
  assign in_range = idx_c < cnt_c;
  assign is_full  = count_q == CntW'(PATH_DEPTH);

  assign red_ctrl.start = accept && (cmd_i.cmd == CMD_SIMPLIFY);
  assign red_ctrl.ack   = red_stat.done && s1_free;

  always_comb begin
    count_d   = count_q;
    do_append = 1'b0;
    do_read   = 1'b0;
    s1_full_d = 1'b0;
    s1_bad_d  = 1'b0;
    s1_load   = red_ctrl.ack;
    if (accept) begin
      unique case (mps_cmd_e'(cmd_i.cmd))
        CMD_APPEND: begin
          s1_load   = 1'b1;
          s1_full_d = is_full;
          do_append = !is_full;
          if (!is_full) begin
            count_d = count_q + CntW'(1);
          end
        end
        CMD_SIMPLIFY: s1_load = 1'b0;
        CMD_READ: begin
          s1_load  = 1'b1;
          s1_bad_d = !in_range;
          do_read  = in_range;
        end
        CMD_CLEAR: begin
          s1_load = 1'b1;
          count_d = '0;
        end
        default: ;
      endcase
    end
    if (red_ctrl.ack) begin
      count_d = red_count;
    end
    s1_len_d   = count_d;
    s1_rd_d    = do_read;
    s1_valid_d = s1_load ? 1'b1 : (out_free ? 1'b0 : s1_valid_q);
  end

  mps_reducer #(
    .PathDepth (PATH_DEPTH)
  ) u_reducer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (red_ctrl),
    .side_i    (side_q),
    .count_i   (count_q),
    .stat_o    (red_stat),
    .count_o   (red_count),
    .pm_o      (red_pm),
    .p_raddr_o (red_raddr),
    .p_waddr_o (red_waddr),
    .p_wdata_o (red_wdata),
    .p_rdata_i (p_rdata_q)
  );

  assign p_we    = red_pm.wr_en || do_append;
  assign p_waddr = red_pm.wr_en ? red_waddr : count_q[AW-1:0];
  assign p_wdata = red_pm.wr_en ? red_wdata : cmd_i.move;
  assign p_re    = red_pm.rd_en || do_read;
  assign p_raddr = red_pm.rd_en ? red_raddr : idx_c[AW-1:0];

  // path store memory
  always_ff @(posedge clk_i) begin
    if (p_we) begin
      p_mem[p_waddr] <= p_wdata;
    end
    if (p_re) begin
      p_rdata_q <= p_mem[p_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q     <= 1'b0;
      count_q    <= '0;
      s1_valid_q <= 1'b0;
      o_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        side_q <= cfg_wdata_i;
      end
      count_q    <= count_d;
      s1_valid_q <= s1_valid_d;
      if (out_free) begin
        o_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_len_q  <= s1_len_d;
      s1_full_q <= s1_full_d;
      s1_bad_q  <= s1_bad_d;
      s1_rd_q   <= s1_rd_d;
    end
    if (out_free && s1_valid_q) begin
      o_move_q <= s1_rd_q ? p_rdata_q : 2'b00;
      o_len_q  <= s1_len_q;
      o_full_q <= s1_full_q;
      o_bad_q  <= s1_bad_q;
    end
  end

  assign res_o.valid       = o_valid_q;
  assign res_o.move_out    = o_move_q;
  assign res_o.path_length = o_len_q;
  assign res_o.full_flag   = o_full_q;
  assign res_o.index_bad   = o_bad_q;

endmodule

FILE: sim/maze_path_simplifier_tb.sv
// testbench of the maze path simplifier: directed table then random routes, checked against a path tracker
`timescale 1ns / 1ps

module maze_path_simplifier_tb;
  import mps_pkg::*;

  localparam int PathDepth   = 256;
  localparam int CycleLimit  = 1_000_000;
  localparam int NumDirected = 23;
  localparam int RandomItems = 300;

  typedef struct packed {
    mps_move_e  mv;
    logic [8:0] len;
    logic       full;
    logic       bad;
  } path_result_t;

  typedef struct {
    mps_cmd_e     cmd;
    mps_move_e    mv;
    logic [7:0]   idx;
    bit           typed;
    path_result_t res;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  mps_in_if cmd_if ();
  mps_out_if #(.CountW(9)) res_if ();

  maze_path_simplifier #(
    .PATH_DEPTH(PathDepth)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .cmd_i      (cmd_if),
    .res_o      (res_if)
  );

  mps_move_e    route_mem [PathDepth];
  mps_move_e    stack_mem [PathDepth];
  int unsigned  route_len;
  logic         wall_side;
  path_result_t pending_results [$];
  int unsigned  errors;
  int unsigned  cycles;
  int unsigned  sent_total;
  bit           calm;
  dir_row_t     dir_rows [NumDirected];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic mps_move_e rnd_move();
    return mps_move_e'($urandom_range(0, 3));
  endfunction

  // turn that replaces a dead end a, U-turn, c for the wall being followed
  function automatic mps_move_e dead_end_turn(input logic side, input mps_move_e a,
                                              input mps_move_e c, output bit hit);
    mps_move_e wall;
    mps_move_e other;
    wall  = side ? MV_L : MV_R;
    other = side ? MV_R : MV_L;
    hit   = 1'b1;
    if (a == wall && c == wall) return MV_F;
    if ((a == MV_F && c == wall) || (a == wall && c == MV_F)) return other;
    if ((a == MV_L && c == MV_R) || (a == MV_R && c == MV_L)) return MV_U;
    hit = 1'b0;
    return MV_L;
  endfunction

  function automatic bit shorten_pass();
    int unsigned depth;
    bit          changed;
    bit          hit;
    mps_move_e   turn;
    depth   = 0;
    changed = 1'b0;
    for (int i = route_len; i > 0; i--) begin
      stack_mem[depth] = route_mem[i-1];
      depth++;
      if (depth >= 3 && stack_mem[depth-2] == MV_U) begin
        turn = dead_end_turn(wall_side, stack_mem[depth-3], stack_mem[depth-1], hit);
        if (hit) begin
          depth -= 3;
          stack_mem[depth] = turn;
          depth++;
          changed = 1'b1;
        end
      end
    end
    for (int i = 0; i < depth; i++) route_mem[i] = stack_mem[depth-1-i];
    route_len = depth;
    return changed;
  endfunction

  function automatic path_result_t track_command(input mps_cmd_e c, input mps_move_e m,
                                                 input logic [7:0] idx);
    path_result_t r;
    r = '{mv: MV_L, len: '0, full: 1'b0, bad: 1'b0};
    case (c)
      CMD_APPEND: begin
        if (route_len < PathDepth) begin
          route_mem[route_len] = m;
          route_len++;
        end else begin
          r.full = 1'b1;
        end
      end
      CMD_SIMPLIFY: begin
        while (shorten_pass()) begin
        end
      end
      CMD_READ: begin
        if (idx < route_len) r.mv = route_mem[idx];
        else r.bad = 1'b1;
      end
      default: route_len = 0;
    endcase
    r.len = route_len[8:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    errors++;
  endtask

  task automatic send_cmd(input mps_cmd_e c, input mps_move_e m, input logic [7:0] idx,
                          input bit typed = 1'b0, input path_result_t typed_res = '0);
    path_result_t r;
    if (!calm && $urandom_range(0, 5) == 0) begin
      cmd_if.valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    cmd_if.valid = 1'b1;
    cmd_if.cmd   = c;
    cmd_if.move  = m;
    cmd_if.index = idx;
    do @(posedge clk); while (!cmd_if.ready);
    r = track_command(c, m, idx);
    pending_results.push_back(typed ? typed_res : r);
    sent_total++;
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    cmd_if.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_wall_side(input logic side);
    wait_for_results();
    cfg_we    = 1'b1;
    cfg_wdata = side;
    @(negedge clk);
    cfg_we    = 1'b0;
    wall_side = side;
  endtask

  // dead-end triples mixed with single moves
  task automatic append_route(input int unsigned n);
    int unsigned k;
    k = 0;
    while (k < n) begin
      if ($urandom_range(0, 1) == 0) begin
        send_cmd(CMD_APPEND, rnd_move(), 8'($urandom_range(0, 255)));
        send_cmd(CMD_APPEND, MV_U, 8'($urandom_range(0, 255)));
        send_cmd(CMD_APPEND, rnd_move(), 8'($urandom_range(0, 255)));
        k += 3;
      end else begin
        send_cmd(CMD_APPEND, rnd_move(), 8'($urandom_range(0, 255)));
        k++;
      end
    end
  endtask

  task automatic read_back();
    for (int k = 0; k < route_len; k++) send_cmd(CMD_READ, rnd_move(), 8'(k));
    if (route_len < PathDepth)
      send_cmd(CMD_READ, rnd_move(), 8'($urandom_range(route_len, 255)));
  endtask

  task automatic dead_end_run();
    if (route_len > 40 || $urandom_range(0, 3) != 0)
      send_cmd(CMD_CLEAR, rnd_move(), 8'($urandom_range(0, 255)));
    append_route($urandom_range(1, 14));
    send_cmd(CMD_SIMPLIFY, rnd_move(), 8'($urandom_range(0, 255)));
    read_back();
  endtask

  task automatic noise_run();
    if (route_len > 40) send_cmd(CMD_CLEAR, rnd_move(), 8'($urandom_range(0, 255)));
    repeat ($urandom_range(4, 10))
      send_cmd(mps_cmd_e'($urandom_range(0, 3)), rnd_move(), 8'($urandom_range(0, 255)));
  endtask

  // full store: dropped appends, then one long simplify
  task automatic fill_store();
    send_cmd(CMD_CLEAR, rnd_move(), 8'($urandom_range(0, 255)));
    while (route_len < PathDepth)
      send_cmd(CMD_APPEND, ($urandom_range(0, 2) == 0) ? MV_U : rnd_move(),
               8'($urandom_range(0, 255)));
    repeat (3) send_cmd(CMD_APPEND, rnd_move(), 8'($urandom_range(0, 255)));
    send_cmd(CMD_READ, rnd_move(), 8'd255);
    send_cmd(CMD_READ, rnd_move(), 8'd0);
    send_cmd(CMD_SIMPLIFY, rnd_move(), 8'($urandom_range(0, 255)));
    if (route_len > 0)
      repeat (6) send_cmd(CMD_READ, rnd_move(), 8'($urandom_range(0, route_len - 1)));
    if (route_len < PathDepth)
      send_cmd(CMD_READ, rnd_move(), 8'($urandom_range(route_len, 255)));
  endtask

  initial begin
    int unsigned hold;
    hold = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && hold != 0) begin
        res_if.ready = 1'b0;
        hold--;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        res_if.ready = 1'b0;
        hold = $urandom_range(1, 15) - 1;
      end else begin
        res_if.ready = 1'b1;
        hold = 0;
      end
    end
  end

  always @(posedge clk) begin
    path_result_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result transaction, path_length", res_if.path_length, 0);
      end else begin
        want = pending_results.pop_front();
        if (res_if.move_out !== want.mv) report_mismatch("move_out", res_if.move_out, want.mv);
        if (res_if.path_length !== want.len)
          report_mismatch("path_length", res_if.path_length, want.len);
        if (res_if.full_flag !== want.full)
          report_mismatch("full_flag", res_if.full_flag, want.full);
        if (res_if.index_bad !== want.bad)
          report_mismatch("index_bad", res_if.index_bad, want.bad);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("maze_path_simplifier_tb: FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned base;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = 1'b0;
    calm          = 1'b0;
    cmd_if.valid  = 1'b0;
    cmd_if.cmd    = CMD_APPEND;
    cmd_if.move   = MV_L;
    cmd_if.index  = '0;
    route_len     = 0;
    wall_side     = 1'b0;
    errors        = 0;
    cycles        = 0;
    sent_total    = 0;
    dir_rows = '{
      '{CMD_READ,     MV_L, 8'd0,   1'b1, '{MV_L, 9'd0, 1'b0, 1'b1}},
      '{CMD_SIMPLIFY, MV_F, 8'd255, 1'b1, '{MV_L, 9'd0, 1'b0, 1'b0}},
      '{CMD_CLEAR,    MV_U, 8'd0,   1'b1, '{MV_L, 9'd0, 1'b0, 1'b0}},
      '{CMD_APPEND,   MV_R, 8'd255, 1'b1, '{MV_L, 9'd1, 1'b0, 1'b0}},
      '{CMD_APPEND,   MV_U, 8'd0,   1'b1, '{MV_L, 9'd2, 1'b0, 1'b0}},
      '{CMD_SIMPLIFY, MV_L, 8'd0,   1'b1, '{MV_L, 9'd2, 1'b0, 1'b0}},
      '{CMD_READ,     MV_L, 8'd1,   1'b1, '{MV_U, 9'd2, 1'b0, 1'b0}},
      '{CMD_APPEND,   MV_R, 8'd170, 1'b1, '{MV_L, 9'd3, 1'b0, 1'b0}},
      '{CMD_SIMPLIFY, MV_L, 8'd85,  1'b0, '0},
      '{CMD_READ,     MV_L, 8'd0,   1'b0, '0},
      '{CMD_READ,     MV_F, 8'd255, 1'b1, '{MV_L, 9'd1, 1'b0, 1'b1}},
      '{CMD_CLEAR,    MV_L, 8'd0,   1'b1, '{MV_L, 9'd0, 1'b0, 1'b0}},
      '{CMD_APPEND,   MV_L, 8'd0,   1'b0, '0},
      '{CMD_APPEND,   MV_U, 8'd0,   1'b0, '0},
      '{CMD_APPEND,   MV_R, 8'd0,   1'b0, '0},
      '{CMD_APPEND,   MV_U, 8'd0,   1'b0, '0},
      '{CMD_APPEND,   MV_F, 8'd0,   1'b0, '0},
      '{CMD_SIMPLIFY, MV_L, 8'd0,   1'b0, '0},
      '{CMD_READ,     MV_L, 8'd0,   1'b0, '0},
      '{CMD_READ,     MV_L, 8'd1,   1'b0, '0},
      '{CMD_READ,     MV_L, 8'd2,   1'b0, '0},
      '{CMD_READ,     MV_L, 8'd3,   1'b0, '0},
      '{CMD_CLEAR,    MV_L, 8'd0,   1'b1, '{MV_L, 9'd0, 1'b0, 1'b0}}
    };
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    set_wall_side(1'b0);

    foreach (dir_rows[r])
      send_cmd(dir_rows[r].cmd, dir_rows[r].mv, dir_rows[r].idx, dir_rows[r].typed,
               dir_rows[r].res);

    base = sent_total;
    for (int ph = 0; sent_total - base < RandomItems; ph++) begin
      set_wall_side((ph % 2 == 0) ? 1'b1 : 1'b0);
      calm = ($urandom_range(0, 3) == 0);
      if (ph == 1) fill_store();
      repeat ($urandom_range(2, 4)) begin
        if ($urandom_range(0, 5) == 0) noise_run();
        else dead_end_run();
      end
    end

    // closing stretch at full rate on both sides
    set_wall_side(1'b0);
    calm = 1'b1;
    repeat (2) dead_end_run();
    set_wall_side(1'b1);
    repeat (2) dead_end_run();

    wait_for_results();
    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("maze_path_simplifier_tb: PASS");
    end else begin
      $display("maze_path_simplifier_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/mps_pkg.sv
rtl/mps_if.sv
rtl/mps_reducer.sv
rtl/maze_path_simplifier.sv
sim/maze_path_simplifier_tb.sv
